### design/tpsd_pkg.sv
// Package for the tone pip sequence detector: types, codes and defaults.
package tpsd_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 10;
    localparam int NOM_WIDTH = 10;
    localparam int TOL_WIDTH = 4;
    localparam int PIPS_WIDTH = 4;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 10;

    typedef enum logic [2:0] {
        PH_WAIT  = 3'd0,
        PH_SHORT = 3'd1,
        PH_GAP   = 3'd2,
        PH_LONG  = 3'd3,
        PH_DET   = 3'd4,
        PH_IDLE  = 3'd5
    } phase_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_SHORT_WINDOWS    = 3'd0,
        REG_LONG_WINDOWS     = 3'd1,
        REG_GAP_WINDOWS      = 3'd2,
        REG_TOLERANCE        = 3'd3,
        REG_PIPS_BEFORE_LONG = 3'd4
    } cfg_index_t;

    localparam logic [NOM_WIDTH-1:0]  SHORT_WINDOWS_RST    = 10'd25;
    localparam logic [NOM_WIDTH-1:0]  LONG_WINDOWS_RST     = 10'd125;
    localparam logic [NOM_WIDTH-1:0]  GAP_WINDOWS_RST      = 10'd225;
    localparam logic [TOL_WIDTH-1:0]  TOLERANCE_RST        = 4'd2;
    localparam logic [PIPS_WIDTH-1:0] PIPS_BEFORE_LONG_RST = 4'd5;

endpackage

### design/tpsd_in_if.sv
// Input channel: one tone-present bit per analysis window.
interface tpsd_in_if;
    logic valid;
    logic ready;
    logic tone_present;

    modport source (output valid, output tone_present, input ready);
    modport sink (input valid, input tone_present, output ready);
endinterface

### design/tpsd_out_if.sv
// Result channel: phase, lamps and detection pulse per window.
interface tpsd_out_if;
    logic valid;
    logic ready;
    logic [2:0] phase;
    logic tone_lamp;
    logic detected_lamp;
    logic detect_pulse;

    modport source (output valid, output phase, output tone_lamp,
                    output detected_lamp, output detect_pulse, input ready);
    modport sink (input valid, input phase, input tone_lamp,
                  input detected_lamp, input detect_pulse, output ready);
endinterface

### design/tpsd_cfg_if.sv
// Configuration write channel: register index and write data.
interface tpsd_cfg_if
    import tpsd_pkg::*;
;
    logic valid;
    logic ready;
    logic [CFG_IDX_WIDTH-1:0] index;
    logic [CFG_DATA_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### design/tone_pip_sequence_detector.sv
// Tone pip sequence detector top level.
// The result of an accepted window is registered in the output register.
// Throughput: one window per cycle unless the output stalls; the state counters update once per window.
// A new window is accepted while the output register is empty or being drained.
// Reset: phase wait, counters and lamps cleared, registers at their defaults.
// Config writes are always accepted; output register empties on reset.
module tone_pip_sequence_detector
    import tpsd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    tpsd_in_if.sink     tone_in,
    tpsd_out_if.source  result_out,
    tpsd_cfg_if.sink    cfg
);

    localparam int CW = COUNT_WIDTH;
    localparam int CMP_W = ((CW > NOM_WIDTH + 2) ? CW : NOM_WIDTH + 2) + 1;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    logic [NOM_WIDTH-1:0]  short_windows_reg;
    logic [NOM_WIDTH-1:0]  long_windows_reg;
    logic [NOM_WIDTH-1:0]  gap_windows_reg;
    logic [TOL_WIDTH-1:0]  tolerance_reg;
    logic [PIPS_WIDTH-1:0] pips_before_long_reg;

    phase_t                phase_reg, phase_next;
    logic [CW-1:0]         run_reg, run_next;
    logic [CW-1:0]         spacing_reg, spacing_next;
    logic [PIPS_WIDTH-1:0] pips_reg, pips_next;
    logic                  tone_lamp_reg, tone_lamp_next;
    logic                  det_lamp_reg, det_lamp_next;
    logic                  pulse_next;

    logic                  out_valid_reg;
    phase_t                out_phase_reg;
    logic                  out_tone_lamp_reg;
    logic                  out_det_lamp_reg;
    logic                  out_pulse_reg;

    logic                  in_acc;
    logic                  tone;
    logic [CW-1:0]         run_inc;
    logic [CW-1:0]         spacing_inc;
    logic [PIPS_WIDTH-1:0] pips_inc;
    logic [CMP_W-1:0]      tol_w;
    logic [CMP_W-1:0]      short_w;
    logic [CMP_W-1:0]      long_w;
    logic [CMP_W-1:0]      gap_w;
    logic [CMP_W-1:0]      gap_lo;
    logic [CMP_W-1:0]      gap_hi;

    function automatic logic in_window(
        input logic [CMP_W-1:0] v,
        input logic [CMP_W-1:0] nominal,
        input logic [CMP_W-1:0] tol
    );
        logic [CMP_W-1:0] lo;
        lo = (nominal > tol) ? nominal - tol : '0;
        return (v >= lo) && (v <= nominal + tol);
    endfunction

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_windows_reg    <= SHORT_WINDOWS_RST;
            long_windows_reg     <= LONG_WINDOWS_RST;
            gap_windows_reg      <= GAP_WINDOWS_RST;
            tolerance_reg        <= TOLERANCE_RST;
            pips_before_long_reg <= PIPS_BEFORE_LONG_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SHORT_WINDOWS:    short_windows_reg <= cfg.data;
                REG_LONG_WINDOWS:     long_windows_reg <= cfg.data;
                REG_GAP_WINDOWS:      gap_windows_reg <= cfg.data;
                REG_TOLERANCE:        tolerance_reg <= cfg.data[TOL_WIDTH-1:0];
                REG_PIPS_BEFORE_LONG: pips_before_long_reg <= cfg.data[PIPS_WIDTH-1:0];
                default:              ;
            endcase
        end
    end

    // handshake
    assign tone_in.ready = !out_valid_reg || result_out.ready;
    assign in_acc = tone_in.valid && tone_in.ready;
    assign tone = tone_in.tone_present;

    assign run_inc     = (run_reg == CNT_MAX) ? CNT_MAX : run_reg + CNT_ONE;
    assign spacing_inc = (spacing_reg == CNT_MAX) ? CNT_MAX : spacing_reg + CNT_ONE;
    assign pips_inc    = pips_reg + PIPS_WIDTH'(1);

    assign tol_w   = CMP_W'(tolerance_reg);
    assign short_w = CMP_W'(short_windows_reg);
    assign long_w  = CMP_W'(long_windows_reg);
    assign gap_w   = CMP_W'(gap_windows_reg);
    assign gap_lo  = (gap_w > tol_w) ? gap_w - tol_w : '0;
    assign gap_hi  = gap_w + tol_w;

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        run_next     = run_reg;
        spacing_next = spacing_inc;
        pips_next    = pips_reg;
        unique case (phase_reg)
            PH_WAIT:
            begin
                spacing_next = '0;
                if (tone)
                begin
                    run_next   = run_inc;
                    phase_next = PH_SHORT;
                end
            end
            PH_SHORT:
            begin
                if (tone)
                begin
                    run_next = run_inc;
                end
                else if (in_window(CMP_W'(run_reg), short_w, tol_w))
                begin
                    if (pips_reg == '0
                        || in_window(CMP_W'(spacing_inc), short_w + gap_w, tol_w))
                    begin
                        phase_next   = PH_GAP;
                        run_next     = CNT_ONE;
                        spacing_next = CNT_ONE;
                    end
                    else
                    begin
                        phase_next = PH_WAIT;
                        run_next   = '0;
                        pips_next  = '0;
                    end
                end
                else
                begin
                    // keeps the pip count
                    phase_next = PH_WAIT;
                    run_next   = '0;
                end
            end
            PH_GAP:
            begin
                run_next = run_inc;
                if (CMP_W'(run_inc) >= gap_lo)
                begin
                    if (tone)
                    begin
                        run_next = CNT_ONE;
                        if (pips_inc == pips_before_long_reg)
                        begin
                            pips_next  = '0;
                            phase_next = PH_LONG;
                        end
                        else
                        begin
                            pips_next  = pips_inc;
                            phase_next = PH_SHORT;
                        end
                    end
                    else if (CMP_W'(run_inc) > gap_hi)
                    begin
                        phase_next = PH_WAIT;
                        run_next   = '0;
                        pips_next  = '0;
                    end
                end
            end
            PH_LONG:
            begin
                if (tone)
                begin
                    run_next = run_inc;
                end
                else if (in_window(CMP_W'(run_reg), long_w, tol_w)
                         && in_window(CMP_W'(spacing_inc), gap_w + long_w, tol_w))
                begin
                    phase_next = PH_DET;
                    run_next   = '0;
                end
                else
                begin
                    phase_next = PH_WAIT;
                    run_next   = '0;
                    pips_next  = '0;
                end
            end
            PH_DET:
            begin
                phase_next = PH_IDLE;
                pips_next  = '0;
            end
            default:
            begin
            end
        endcase
    end

    // lamps and pulse
    always_comb
    begin
        tone_lamp_next = tone_lamp_reg;
        det_lamp_next  = det_lamp_reg;
        pulse_next     = 1'b0;
        unique case (phase_reg)
            PH_WAIT:  tone_lamp_next = 1'b0;
            PH_SHORT:
            begin
                if (tone)
                begin
                    tone_lamp_next = 1'b1;
                end
            end
            PH_GAP:   tone_lamp_next = 1'b0;
            PH_LONG:  tone_lamp_next = 1'b1;
            PH_DET:
            begin
                det_lamp_next  = 1'b1;
                tone_lamp_next = 1'b0;
                pulse_next     = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            run_reg       <= '0;
            spacing_reg   <= '0;
            pips_reg      <= '0;
            tone_lamp_reg <= 1'b0;
            det_lamp_reg  <= 1'b0;
        end
        else if (in_acc)
        begin
            phase_reg     <= phase_next;
            run_reg       <= run_next;
            spacing_reg   <= spacing_next;
            pips_reg      <= pips_next;
            tone_lamp_reg <= tone_lamp_next;
            det_lamp_reg  <= det_lamp_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            out_phase_reg     <= phase_next;
            out_tone_lamp_reg <= tone_lamp_next;
            out_det_lamp_reg  <= det_lamp_next;
            out_pulse_reg     <= pulse_next;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.phase         = out_phase_reg;
    assign result_out.tone_lamp     = out_tone_lamp_reg;
    assign result_out.detected_lamp = out_det_lamp_reg;
    assign result_out.detect_pulse  = out_pulse_reg;

`ifndef SYNTHESIS
    a_pulse_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.detect_pulse |-> result_out.detected_lamp)
        else $error("detect pulse without detected lamp");

    a_det_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && phase_reg == PH_DET |=> phase_reg == PH_IDLE)
        else $error("detected phase did not move to idle");

    a_lamp_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        det_lamp_reg |=> det_lamp_reg)
        else $error("detected lamp cleared");

    a_wait_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && phase_reg == PH_WAIT |=> spacing_reg == '0)
        else $error("spacing not cleared while waiting");
`endif

endmodule

### tb/tb.sv
// Testbench for the tone pip sequence detector: directed and random window streams.
module tb;
    import tpsd_pkg::*;

    localparam int CW = COUNT_WIDTH_DEFAULT;

    typedef struct packed {
        phase_t phase;
        logic   tone_lamp;
        logic   detected_lamp;
        logic   detect_pulse;
    } window_result_t;

    logic clk = 1'b0;
    logic rst_n;

    tpsd_in_if  tone_in();
    tpsd_out_if result_out();
    tpsd_cfg_if cfg();

    tone_pip_sequence_detector i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tone_in    (tone_in),
        .result_out (result_out),
        .cfg        (cfg)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Detector model state and configuration
    logic [NOM_WIDTH-1:0]  short_q;
    logic [NOM_WIDTH-1:0]  long_q;
    logic [NOM_WIDTH-1:0]  gap_q;
    logic [TOL_WIDTH-1:0]  tol_q;
    logic [PIPS_WIDTH-1:0] pip_target_q;
    phase_t                phase_q;
    logic [CW-1:0]         run_q;
    logic [CW-1:0]         spacing_q;
    logic [PIPS_WIDTH-1:0] pips_q;
    logic                  tone_lamp_q;
    logic                  det_lamp_q;

    window_result_t pending_windows[$];
    int mismatches = 0;
    int windows_sent = 0;

    // Sender and receiver pacing
    bit gappy = 1'b1;
    int burst_left = 0;
    int stall_pct = 20;
    int stall_left = 0;
    int hold_req = 0;
    int hold_left = 0;

    function automatic logic [CW-1:0] bump(logic [CW-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic bit in_window(int v, int nominal);
        int lo;
        lo = (nominal > int'(tol_q)) ? nominal - int'(tol_q) : 0;
        return (v >= lo) && (v <= nominal + int'(tol_q));
    endfunction

    task automatic restart_sequence();
        phase_q = PH_WAIT;
        run_q = '0;
        pips_q = '0;
    endtask

    task automatic advance_window(input logic tone, output window_result_t r);
        int gap_lo;
        logic pulse;
        pulse = 1'b0;
        spacing_q = bump(spacing_q);
        case (phase_q)
            PH_WAIT:
            begin
                spacing_q = '0;
                tone_lamp_q = 1'b0;
                if (tone)
                begin
                    run_q = bump(run_q);
                    phase_q = PH_SHORT;
                end
            end
            PH_SHORT:
            begin
                if (tone)
                begin
                    run_q = bump(run_q);
                    tone_lamp_q = 1'b1;
                end
                else if (in_window(int'(run_q), int'(short_q)))
                begin
                    if (pips_q == '0 ||
                        in_window(int'(spacing_q), int'(short_q) + int'(gap_q)))
                    begin
                        phase_q = PH_GAP;
                        run_q = CW'(1);
                        spacing_q = CW'(1);
                    end
                    else
                        restart_sequence();
                end
                else
                begin
                    phase_q = PH_WAIT;
                    run_q = '0;
                end
            end
            PH_GAP:
            begin
                tone_lamp_q = 1'b0;
                run_q = bump(run_q);
                gap_lo = (int'(gap_q) > int'(tol_q)) ? int'(gap_q) - int'(tol_q) : 0;
                if (int'(run_q) >= gap_lo)
                begin
                    if (tone)
                    begin
                        pips_q = pips_q + 1'b1;
                        if (pips_q == pip_target_q)
                        begin
                            pips_q = '0;
                            phase_q = PH_LONG;
                        end
                        else
                            phase_q = PH_SHORT;
                        run_q = CW'(1);
                    end
                    else if (int'(run_q) > int'(gap_q) + int'(tol_q))
                        restart_sequence();
                end
            end
            PH_LONG:
            begin
                tone_lamp_q = 1'b1;
                if (tone)
                    run_q = bump(run_q);
                else if (in_window(int'(run_q), int'(long_q)) &&
                         in_window(int'(spacing_q), int'(gap_q) + int'(long_q)))
                begin
                    phase_q = PH_DET;
                    run_q = '0;
                end
                else
                    restart_sequence();
            end
            PH_DET:
            begin
                det_lamp_q = 1'b1;
                tone_lamp_q = 1'b0;
                phase_q = PH_IDLE;
                pips_q = '0;
                pulse = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.phase = phase_q;
        r.tone_lamp = tone_lamp_q;
        r.detected_lamp = det_lamp_q;
        r.detect_pulse = pulse;
    endtask

    task automatic check_field(string what, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Scoreboard: retire results first, then predict the newly accepted window
    always @(posedge clk)
    begin
        window_result_t want;
        window_result_t next;
        if (result_out.valid && result_out.ready)
        begin
            if (pending_windows.size() == 0)
            begin
                $display("%0t: unexpected result transaction, phase %0d", $time,
                         result_out.phase);
                mismatches++;
            end
            else
            begin
                want = pending_windows.pop_front();
                check_field("phase", want.phase, result_out.phase);
                check_field("tone_lamp", want.tone_lamp, result_out.tone_lamp);
                check_field("detected_lamp", want.detected_lamp, result_out.detected_lamp);
                check_field("detect_pulse", want.detect_pulse, result_out.detect_pulse);
            end
        end
        if (tone_in.valid && tone_in.ready)
        begin
            advance_window(tone_in.tone_present, next);
            pending_windows.push_back(next);
        end
    end

    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_out.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_out.ready <= 1'b0;
        end
        else if (int'($urandom_range(1, 100)) <= stall_pct)
        begin
            stall_left = $urandom_range(0, 5);
            result_out.ready <= 1'b0;
        end
        else
            result_out.ready <= 1'b1;
    end

    task automatic send_window(input logic tone);
        if (gappy)
        begin
            if (burst_left == 0)
            begin
                tone_in.valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        tone_in.valid <= 1'b1;
        tone_in.tone_present <= tone;
        do
            @(posedge clk);
        while (!tone_in.ready);
        windows_sent++;
    endtask

    task automatic send_run(input logic tone, input int n);
        repeat (n) send_window(tone);
    endtask

    task automatic send_noise(input int n);
        int bias;
        bias = $urandom_range(20, 80);
        repeat (n) send_window(int'($urandom_range(1, 100)) <= bias);
    endtask

    // Flush to wait, then pips near nominal, then a tone of the given length
    task automatic send_train(input int n_pips, input int long_len, input int jitter);
        int i;
        int dev;
        int pip_len;
        int gap_len;
        send_run(1'b0, int'(gap_q) + int'(tol_q) + 2);
        for (i = 0; i < n_pips; i++)
        begin
            dev = (jitter > 0) ? int'($urandom_range(0, 2 * jitter)) - jitter : 0;
            pip_len = int'(short_q) + dev;
            if (pip_len < 1)
                pip_len = 1;
            gap_len = int'(gap_q) - 1 - dev;
            if ($urandom_range(0, 9) == 0)
                gap_len += int'($urandom_range(0, 2)) - 1;
            if (gap_len < 1)
                gap_len = 1;
            send_run(1'b1, pip_len);
            send_run(1'b0, gap_len);
        end
        send_run(1'b1, long_len);
        send_run(1'b0, 1);
    endtask

    task automatic wait_idle();
        tone_in.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_windows.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_WIDTH-1:0] d);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= d;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            REG_SHORT_WINDOWS:    short_q = d;
            REG_LONG_WINDOWS:     long_q = d;
            REG_GAP_WINDOWS:      gap_q = d;
            REG_TOLERANCE:        tol_q = d[TOL_WIDTH-1:0];
            REG_PIPS_BEFORE_LONG: pip_target_q = d[PIPS_WIDTH-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic load_config(input int s, l, g, t, p);
        wait_idle();
        write_reg(REG_SHORT_WINDOWS, CFG_DATA_WIDTH'(s));
        write_reg(REG_LONG_WINDOWS, CFG_DATA_WIDTH'(l));
        write_reg(REG_GAP_WINDOWS, CFG_DATA_WIDTH'(g));
        write_reg(REG_TOLERANCE, CFG_DATA_WIDTH'(t));
        write_reg(REG_PIPS_BEFORE_LONG, CFG_DATA_WIDTH'(p));
        cfg.valid <= 1'b0;
    endtask

    task automatic test_reset_values();
        send_run(1'b1, 25);
        send_run(1'b0, 12);
    endtask

    task automatic test_short_length_bounds();
        load_config(4, 10, 5, 1, 3);
        send_run(1'b0, 8);
        send_run(1'b1, 2);
        send_run(1'b0, 8);
        send_run(1'b1, 3);
        send_run(1'b0, 4);
        send_run(1'b1, 5);
        send_run(1'b0, 4);
        send_run(1'b1, 7);
        send_run(1'b0, 2);
        // pip count kept after a bad length: next first pip is spacing checked
        send_train(2, 4, 0);
    endtask

    task automatic test_zero_nominals();
        load_config(0, 0, 0, 0, 1);
        send_noise(12);
        send_run(1'b1, 3);
        send_run(1'b0, 2);
        load_config(10'h3FF, 0, 0, 0, 1);
        send_noise(10);
    endtask

    task automatic test_tolerance_clamp();
        load_config(3, 600, 6, 10'h3FF, 15);
        send_run(1'b0, 4);
        send_run(1'b1, 1);
        send_run(1'b0, 6);
        send_run(1'b1, 18);
        send_run(1'b0, 6);
        send_run(1'b1, 19);
        send_run(1'b0, 3);
    endtask

    task automatic test_pip_count_wrap();
        load_config(1, 20, 2, 0, 0);
        send_run(1'b0, 6);
        repeat (16)
        begin
            send_run(1'b1, 1);
            send_run(1'b0, 1);
        end
        send_run(1'b1, 5);
        send_run(1'b0, 1);
    endtask

    task automatic test_receiver_holdoff();
        load_config(3, 12, 4, 1, 3);
        gappy = 1'b0;
        stall_pct = 0;
        hold_req = 60;
        repeat (4) send_train(3, 5, 1);
        gappy = 1'b1;
        stall_pct = 20;
    endtask

    task automatic test_random_sequences();
        int first;
        int s;
        int g;
        int t;
        int l;
        int n;
        int lng;
        first = windows_sent;
        while (windows_sent - first < 450)
        begin
            s = $urandom_range(1, 6);
            g = $urandom_range(1, 8);
            t = $urandom_range(0, 2);
            l = s + 2 * t + 2 + int'($urandom_range(0, 6));
            load_config(s, l, g, ($urandom_range(0, 63) << 4) | t,
                        ($urandom_range(0, 63) << 4) | $urandom_range(1, 5));
            gappy = $urandom_range(0, 1);
            stall_pct = 15 * int'($urandom_range(0, 3));
            repeat ($urandom_range(3, 8))
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    n = ($urandom_range(0, 3) != 0) ? int'(pip_target_q) :
                        int'($urandom_range(1, pip_target_q));
                    // long tone always off nominal so the sequence is rejected
                    lng = $urandom_range(0, 1) ? l + t + 1 + int'($urandom_range(0, 2)) :
                          int'($urandom_range(1, l - t - 1));
                    send_train(n, lng, $urandom_range(0, 1) ? t : 0);
                end
                else
                    send_noise($urandom_range(4, 30));
            end
        end
        gappy = 1'b1;
        stall_pct = 20;
    endtask

    task automatic test_full_detection();
        load_config(2, 8, 4, 1, 2);
        // a clean pip followed by a timed-out gap clears any stale pip count
        send_run(1'b0, 8);
        send_run(1'b1, 2);
        send_run(1'b0, 8);
        send_train(2, 8, 0);
        send_noise(8);
    endtask

    initial
    begin
        rst_n = 1'b0;
        tone_in.valid = 1'b0;
        tone_in.tone_present = 1'b0;
        result_out.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_SHORT_WINDOWS;
        cfg.data = '0;
        short_q = SHORT_WINDOWS_RST;
        long_q = LONG_WINDOWS_RST;
        gap_q = GAP_WINDOWS_RST;
        tol_q = TOLERANCE_RST;
        pip_target_q = PIPS_BEFORE_LONG_RST;
        phase_q = PH_WAIT;
        run_q = '0;
        spacing_q = '0;
        pips_q = '0;
        tone_lamp_q = 1'b0;
        det_lamp_q = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_short_length_bounds();
        test_zero_nominals();
        test_tolerance_clamp();
        test_pip_count_wrap();
        test_receiver_holdoff();
        test_random_sequences();
        test_full_detection();
        wait_idle();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #600000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
design/tpsd_pkg.sv
design/tpsd_in_if.sv
design/tpsd_out_if.sv
design/tpsd_cfg_if.sv
design/tone_pip_sequence_detector.sv
tb/tb.sv
